### design/spbe_pkg.sv
// shared types and constants for the stego pair bit extractor
`timescale 1ns / 1ps
package spbe_pkg;

  localparam int unsigned THR_W       = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd8;
  localparam int unsigned LEN_W       = 24;
  localparam logic [1:0] HDR_BYTES    = 2'd3;
  localparam logic [1:0] TOP_SLOT     = 2'd3;
  localparam logic [1:0] CH_LUMA      = 2'd0;

  localparam int unsigned CMDQ_DEPTH  = 4;
  localparam int unsigned CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam int unsigned RESQ_DEPTH  = 2;
  localparam int unsigned RESQ_AW     = $clog2(RESQ_DEPTH);

  // classified pair handed from the front to the back
  typedef struct packed {
    logic       frame_start;
    logic       used;
    logic [1:0] bits;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] message_length;
  } result_t;

endpackage

### design/spbe_front.sv
// front end: threshold register and pair classification
`timescale 1ns / 1ps
module spbe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [spbe_pkg::THR_W-1:0] cfg_diff_threshold,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_frame_start,
  input  logic [1:0]                in_channel,
  input  logic [7:0]                in_prev_sample,
  input  logic [7:0]                in_curr_sample,
  input  logic                      q_full,
  output logic                      q_push,
  output spbe_pkg::cmd_t            q_cmd
);
  import spbe_pkg::*;

  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [7:0]       mag;
  logic             used;

  assign cfg_ready = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_valid) begin
      thr_nxt = cfg_diff_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign mag  = (in_curr_sample >= in_prev_sample) ? (in_curr_sample - in_prev_sample)
                                                   : (in_prev_sample - in_curr_sample);
  assign used = (in_channel != CH_LUMA) && ({1'b0, mag} >= thr_r);

  // ((prev >> 1) + curr) & 1 is just prev[1] ^ curr[0]
  always_comb begin
    q_cmd.frame_start = in_frame_start;
    q_cmd.used        = used;
    q_cmd.bits        = {in_prev_sample[0], in_prev_sample[1] ^ in_curr_sample[0]};
  end

  // pairs that neither clear nor carry bits never enter the queue
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && (in_frame_start || used);

endmodule

### design/spbe_cmd_queue.sv
// small fifo of classified pairs between front and back
`timescale 1ns / 1ps
module spbe_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  spbe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output spbe_pkg::cmd_t head
);
  import spbe_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/spbe_back.sv
// back end: bit packing, header decode, payload count and result buffer
`timescale 1ns / 1ps
module spbe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  spbe_pkg::cmd_t              q_head,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [7:0]                  out_payload_byte,
  output logic                        out_byte_valid,
  output logic                        out_last,
  output logic [spbe_pkg::LEN_W-1:0]  out_message_length
);
  import spbe_pkg::*;

  logic [1:0]       slot_r, slot_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [1:0]       hc_r, hc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pc_r, pc_nxt;
  logic             fin_r, fin_nxt;

  logic [1:0]       s_slot;
  logic [7:0]       s_acc;
  logic [1:0]       s_hc;
  logic [LEN_W-1:0] s_len;
  logic [LEN_W-1:0] s_pc;
  logic             s_fin;
  logic [7:0]       acc_new;
  logic [LEN_W-1:0] len_shift;
  logic [LEN_W-1:0] pc_inc;

  result_t            res_mem [RESQ_DEPTH];
  logic [RESQ_AW-1:0] res_wp_r, res_rp_r;
  logic [RESQ_AW:0]   res_cnt_r, res_cnt_nxt;
  logic               res_wr, res_rd, res_space;
  result_t            res_data, res_head;

  assign res_rd    = out_pop && (res_cnt_r != '0);
  assign res_space = (res_cnt_r != (RESQ_AW+1)'(RESQ_DEPTH)) || res_rd;
  assign q_pop     = !q_empty && res_space;

  always_comb begin
    s_slot = q_head.frame_start ? TOP_SLOT : slot_r;
    s_acc  = q_head.frame_start ? 8'd0 : acc_r;
    s_hc   = q_head.frame_start ? 2'd0 : hc_r;
    s_len  = q_head.frame_start ? '0 : len_r;
    s_pc   = q_head.frame_start ? '0 : pc_r;
    s_fin  = q_head.frame_start ? 1'b0 : fin_r;

    acc_new   = s_acc | ({6'd0, q_head.bits} << {s_slot, 1'b0});
    len_shift = {s_len[LEN_W-9:0], acc_new};
    pc_inc    = s_pc + 1'b1;

    slot_nxt = slot_r;
    acc_nxt  = acc_r;
    hc_nxt   = hc_r;
    len_nxt  = len_r;
    pc_nxt   = pc_r;
    fin_nxt  = fin_r;
    res_wr   = 1'b0;
    res_data = '0;

    if (q_pop) begin
      slot_nxt = s_slot;
      acc_nxt  = s_acc;
      hc_nxt   = s_hc;
      len_nxt  = s_len;
      pc_nxt   = s_pc;
      fin_nxt  = s_fin;
      if (!s_fin && q_head.used) begin
        if (s_slot != 2'd0) begin
          slot_nxt = s_slot - 1'b1;
          acc_nxt  = acc_new;
        end else begin
          slot_nxt = TOP_SLOT;
          acc_nxt  = 8'd0;
          if (s_hc != HDR_BYTES) begin
            // header byte: shift into the length, big-endian
            len_nxt = len_shift;
            hc_nxt  = s_hc + 1'b1;
            if ((s_hc == HDR_BYTES - 2'd1) && (len_shift == '0)) begin
              fin_nxt                 = 1'b1;
              res_wr                  = 1'b1;
              res_data.last           = 1'b1;
              res_data.message_length = '0;
            end
          end else begin
            pc_nxt                  = pc_inc;
            res_wr                  = 1'b1;
            res_data.payload_byte   = acc_new;
            res_data.byte_valid     = 1'b1;
            res_data.message_length = s_len;
            if (pc_inc == s_len) begin
              fin_nxt       = 1'b1;
              res_data.last = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= TOP_SLOT;
      acc_r  <= 8'd0;
      hc_r   <= 2'd0;
      len_r  <= '0;
      pc_r   <= '0;
      fin_r  <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      acc_r  <= acc_nxt;
      hc_r   <= hc_nxt;
      len_r  <= len_nxt;
      pc_r   <= pc_nxt;
      fin_r  <= fin_nxt;
    end
  end

  // two-entry result buffer
  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_wr && !res_rd) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (res_rd && !res_wr) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wp_r  <= '0;
      res_rp_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
      if (res_wr) begin
        res_wp_r <= res_wp_r + 1'b1;
      end
      if (res_rd) begin
        res_rp_r <= res_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem[res_wp_r] <= res_data;
    end
  end

  assign res_head           = res_mem[res_rp_r];
  assign out_empty          = (res_cnt_r == '0);
  assign out_payload_byte   = res_head.payload_byte;
  assign out_byte_valid     = res_head.byte_valid;
  assign out_last           = res_head.last;
  assign out_message_length = res_head.message_length;

`ifndef ASSERT_OFF
  a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= (RESQ_AW+1)'(RESQ_DEPTH))
    else $error("result buffer overfilled");

  a_fin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && q_pop && !q_head.frame_start) |-> !res_wr)
    else $error("result produced after message end");

  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HDR_BYTES)
    else $error("header count overran");

  a_fin_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> (hc_r == HDR_BYTES))
    else $error("finished before header complete");
`endif

endmodule

### design/stego_pair_bit_extractor_unit.sv
// top level of the stego pair bit extractor
// a pair that completes a byte goes into the registered command queue, where it waits while
//   the result buffer is full, then through the back end into the registered result buffer
// throughput: one pair per cycle while the result buffer has room, set by the back-end update of the packing state
// reset (synchronous, rst_n low): queues empty, extraction state cleared, threshold back to 8
// no memory clearing pass is needed after reset
`timescale 1ns / 1ps
module stego_pair_bit_extractor_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [spbe_pkg::THR_W-1:0]  cfg_diff_threshold,
  // input pairs
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_frame_start,
  input  logic [1:0]                  in_channel,
  input  logic [7:0]                  in_prev_sample,
  input  logic [7:0]                  in_curr_sample,
  // results
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [7:0]                  out_payload_byte,
  output logic                        out_byte_valid,
  output logic                        out_last,
  output logic [spbe_pkg::LEN_W-1:0]  out_message_length
);
  import spbe_pkg::*;

  // front to queue
  logic q_push, q_full;
  cmd_t q_cmd;
  // queue to back
  logic q_pop, q_empty;
  cmd_t q_head;

  // front: holds the threshold, works out |curr - prev| and the two bits,
  // and drops luma or low-contrast pairs unless they carry a frame start
  spbe_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_diff_threshold (cfg_diff_threshold),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_frame_start     (in_frame_start),
    .in_channel         (in_channel),
    .in_prev_sample     (in_prev_sample),
    .in_curr_sample     (in_curr_sample),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (q_cmd)
  );

  // decouples the front from back-end stalls caused by a full result buffer
  spbe_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: packs bit pairs msb first into bytes, collects the three length
  // bytes, then emits payload bytes until the length is reached
  spbe_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_payload_byte   (out_payload_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_message_length (out_message_length)
  );

endmodule

### tb/sv/stego_pair_bit_extractor_checker.sv
// checker that predicts the extracted payload bytes and compares them with the block's results
`timescale 1ns / 1ps
module stego_pair_bit_extractor_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [spbe_pkg::THR_W-1:0] cfg_diff_threshold,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic                       in_frame_start,
  input  logic [1:0]                 in_channel,
  input  logic [7:0]                 in_prev_sample,
  input  logic [7:0]                 in_curr_sample,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic [7:0]                 out_payload_byte,
  input  logic                       out_byte_valid,
  input  logic                       out_last,
  input  logic [spbe_pkg::LEN_W-1:0] out_message_length,
  output int                         fail_count,
  output int                         in_flight,
  output int                         results_seen,
  output int                         messages_done
);
  import spbe_pkg::*;

  logic [THR_W-1:0] threshold;
  logic [1:0]       slot;
  logic [7:0]       accum;
  logic [1:0]       hdr_count;
  logic [LEN_W-1:0] msg_len;
  logic [LEN_W-1:0] byte_count;
  logic             done;

  result_t expected_bytes[$];

  task automatic restart_message();
    slot       = TOP_SLOT;
    accum      = '0;
    hdr_count  = '0;
    msg_len    = '0;
    byte_count = '0;
    done       = 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic valid, input logic fin);
    result_t r;
    r.payload_byte   = b;
    r.byte_valid     = valid;
    r.last           = fin;
    r.message_length = msg_len;
    expected_bytes.push_back(r);
  endtask

  task automatic extract_pair(input logic fs, input logic [1:0] ch,
                              input logic [7:0] p, input logic [7:0] c);
    logic [8:0] mag;
    logic [1:0] sym;
    logic [7:0] b;
    if (fs) restart_message();
    if (done || ch == CH_LUMA) return;
    mag = (c >= p) ? {1'b0, c} - {1'b0, p} : {1'b0, p} - {1'b0, c};
    if (mag < threshold) return;
    // lsb of (p >> 1) + c is p[1] xor c[0]
    sym   = {p[0], p[1] ^ c[0]};
    accum = accum | (8'(sym) << (2 * slot));
    if (slot != 2'd0) begin
      slot = slot - 2'd1;
      return;
    end
    b     = accum;
    accum = '0;
    slot  = TOP_SLOT;
    if (hdr_count < HDR_BYTES) begin
      msg_len   = {msg_len[LEN_W-9:0], b};
      hdr_count = hdr_count + 2'd1;
      if (hdr_count == HDR_BYTES && msg_len == '0) begin
        done = 1'b1;
        queue_byte(8'd0, 1'b0, 1'b1);
      end
      return;
    end
    byte_count = byte_count + 1'b1;
    done       = (byte_count == msg_len);
    queue_byte(b, 1'b1, done);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: byte %0d valid %0d last %0d length %0d",
             out_payload_byte, out_byte_valid, out_last, out_message_length);
      fail_count++;
      return;
    end
    want = expected_bytes.pop_front();
    results_seen++;
    if (want.last) messages_done++;
    if (out_payload_byte !== want.payload_byte) begin
      $error("payload_byte: expected %0d, got %0d", want.payload_byte, out_payload_byte);
      fail_count++;
    end
    if (out_byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0d, got %0d", want.byte_valid, out_byte_valid);
      fail_count++;
    end
    if (out_last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, out_last);
      fail_count++;
    end
    if (out_message_length !== want.message_length) begin
      $error("message_length: expected %0d, got %0d", want.message_length, out_message_length);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THR_RESET;
      restart_message();
      expected_bytes.delete();
      fail_count    = 0;
      results_seen  = 0;
      messages_done = 0;
    end else begin
      if (!out_empty && out_pop) check_result();
      // a pair taken at the same edge as a write still sees the old threshold
      if (in_push && !in_full)
        extract_pair(in_frame_start, in_channel, in_prev_sample, in_curr_sample);
      if (cfg_valid && cfg_ready) threshold = cfg_diff_threshold;
    end
    in_flight <= expected_bytes.size();
  end

endmodule

### tb/sv/stego_pair_bit_extractor_unit_tb.sv
// testbench top for the stego pair bit extractor: stimulus, receiver and verdict
`timescale 1ns / 1ps
module stego_pair_bit_extractor_unit_tb;
  import spbe_pkg::*;

  // input items that the random part aims for
  localparam int ITEM_TARGET = 1950;
  // receiver hold-off long enough to back the block up to its input
  localparam int LONG_HOLD = 400;
  // cycles allowed for pairs that give no result to leave the block
  localparam int SETTLE = 8;
  // frames are only built where a pair can carry every two-bit symbol
  localparam int FRAME_THR_MAX = 192;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_diff_threshold = '0;

  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_frame_start = 1'b0;
  logic [1:0] in_channel = '0;
  logic [7:0] in_prev_sample = '0;
  logic [7:0] in_curr_sample = '0;

  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [7:0]       out_payload_byte;
  logic             out_byte_valid;
  logic             out_last;
  logic [LEN_W-1:0] out_message_length;

  int fail_count;
  int in_flight;
  int results_seen;
  int messages_done;

  // threshold the block holds now, mirrored for building pairs
  int cur_thr = THR_RESET;
  int frame_pairs = 0;
  int items_sent = 0;
  int settings_used = 0;
  // no idling on either side while set
  bit steady = 1'b0;
  bit long_hold_req = 1'b0;
  int pop_hold = 0;

  always #2 clk = ~clk;

  stego_pair_bit_extractor_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_diff_threshold (cfg_diff_threshold),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_frame_start     (in_frame_start),
    .in_channel         (in_channel),
    .in_prev_sample     (in_prev_sample),
    .in_curr_sample     (in_curr_sample),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_payload_byte   (out_payload_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_message_length (out_message_length)
  );

  stego_pair_bit_extractor_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_diff_threshold (cfg_diff_threshold),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_frame_start     (in_frame_start),
    .in_channel         (in_channel),
    .in_prev_sample     (in_prev_sample),
    .in_curr_sample     (in_curr_sample),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_payload_byte   (out_payload_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_message_length (out_message_length),
    .fail_count         (fail_count),
    .in_flight          (in_flight),
    .results_seen       (results_seen),
    .messages_done      (messages_done)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic int absdiff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // pick a pair that the block uses at threshold thr and that carries sym;
  // first bit is the lsb of prev, second the lsb of (prev >> 1) + curr
  function automatic logic [15:0] encode_pair(input logic [1:0] sym, input int thr);
    int p;
    int c;
    bit ok;
    ok = 1'b0;
    p  = 0;
    c  = 0;
    while (!ok) begin
      p = ($urandom_range(127, 0) << 1) | sym[1];
      if (p + thr <= 255 && (p < thr || $urandom_range(1, 0) == 1)) begin
        c  = $urandom_range(255, p + thr);
        ok = 1'b1;
      end else if (p >= thr) begin
        c  = $urandom_range(p - thr, 0);
        ok = 1'b1;
      end
      // nudge curr by one to fix the second bit, keeping the difference
      if (ok && ((p >> 1) + c) % 2 != sym[0]) begin
        if (c < 255 && absdiff(c + 1, p) >= thr) c = c + 1;
        else if (c > 0 && absdiff(c - 1, p) >= thr) c = c - 1;
        else ok = 1'b0;
      end
    end
    return {p[7:0], c[7:0]};
  endfunction

  // offer one pair, after an optional gap, and hold it until the block takes it
  task automatic send_pair(input logic fs, input logic [1:0] ch,
                           input logic [7:0] p, input logic [7:0] c);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_frame_start <= fs;
    in_channel     <= ch;
    in_prev_sample <= p;
    in_curr_sample <= c;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  // a pair that leaves the packing state alone (luma or below threshold),
  // or with wild set any pair at all, now and then with frame_start
  task automatic send_noise(input logic fs, input bit wild);
    int p;
    int lo;
    int hi;
    int kind;
    kind = wild ? $urandom_range(3, 0) : $urandom_range(1, 0);
    p    = $urandom_range(255, 0);
    if (kind == 0 || cur_thr == 0) begin
      send_pair(fs, CH_LUMA, 8'(p), 8'($urandom_range(255, 0)));
    end else if (kind == 1) begin
      lo = (p - cur_thr + 1 < 0) ? 0 : p - cur_thr + 1;
      hi = (p + cur_thr - 1 > 255) ? 255 : p + cur_thr - 1;
      send_pair(fs, 2'($urandom_range(3, 1)), 8'(p), 8'($urandom_range(hi, lo)));
    end else begin
      send_pair(fs | ($urandom_range(19, 0) == 0), 2'($urandom_range(3, 0)), 8'(p),
                8'($urandom_range(255, 0)));
    end
  endtask

  // one message: three length bytes then payload, nbytes in all; fewer than
  // 3 + len leaves it unfinished, more sends pairs that are to be ignored
  task automatic send_frame(input int len, input int nbytes, input bit noisy);
    logic [7:0]  b;
    logic [15:0] pc;
    bit          first;
    int          k;
    int          s;
    first = 1'b1;
    for (k = 0; k < nbytes; k++) begin
      case (k)
        0:       b = len[23:16];
        1:       b = len[15:8];
        2:       b = len[7:0];
        default: b = 8'($urandom);
      endcase
      // two bits per pair, most significant first
      for (s = 3; s >= 0; s--) begin
        if (noisy && $urandom_range(9, 0) == 0) begin
          send_noise(first, 1'b0);
          first = 1'b0;
        end
        pc = encode_pair(b[2*s +: 2], cur_thr);
        send_pair(first, 2'($urandom_range(3, 1)), pc[15:8], pc[7:0]);
        first = 1'b0;
        frame_pairs++;
      end
    end
  endtask

  // sender pauses until every predicted result has been taken, then lets
  // pairs that give no result work their way out
  task automatic wait_quiet();
    in_push <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_threshold(input int thr);
    wait_quiet();
    cfg_valid          <= 1'b1;
    cfg_diff_threshold <= THR_W'(thr);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_thr = thr;
    settings_used++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      pop_hold = LONG_HOLD;
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else begin
      pop_hold = steady ? 0 : idle_len();
      out_pop <= (pop_hold == 0);
    end
  end

  initial begin
    int thr;
    int phase;
    int r;
    int len;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, threshold still at its reset value
    // luma pair at the sample extremes, then channel three below threshold
    send_pair(1'b1, CH_LUMA, 8'd255, 8'd255);
    send_pair(1'b0, 2'd3, 8'd128, 8'd128);
    // zero length header gives the empty end item
    send_frame(0, 3, 1'b0);
    // after completion this is ignored
    send_pair(1'b0, 2'd2, 8'd0, 8'd255);
    // new frame: extremes on channel three and one, difference right at threshold
    send_pair(1'b1, 2'd3, 8'd0, 8'd255);
    send_pair(1'b0, 2'd1, 8'd255, 8'd0);
    send_pair(1'b0, 2'd2, 8'd0, 8'd8);
    // one below threshold, then one at threshold closing the first length byte
    send_pair(1'b0, 2'd1, 8'd10, 8'd3);
    send_pair(1'b0, 2'd1, 8'd9, 8'd1);

    // random part, one threshold per phase
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       thr = 0;
        1:       thr = 1;
        2:       thr = 256;
        3:       thr = 255;
        4:       thr = THR_RESET;
        5:       thr = FRAME_THR_MAX;
        default: thr = ($urandom_range(9, 0) == 0) ? $urandom_range(256, FRAME_THR_MAX + 1)
                                                   : $urandom_range(FRAME_THR_MAX, 0);
      endcase
      set_threshold(thr);
      steady = (phase % 4 == 3);

      if (phase == 1) begin
        // receiver holds off while a long message streams in without gaps,
        // so the block fills and pushes back on its input
        steady = 1'b1;
        long_hold_req = 1'b1;
        send_frame(40, 44, 1'b0);
        steady = 1'b0;
      end

      if (thr > FRAME_THR_MAX) begin
        // well-formed frames are out of reach here, so only loose pairs
        repeat (40) send_noise($urandom_range(9, 0) == 0, 1'b1);
      end else begin
        repeat (4) begin
          r = $urandom_range(99, 0);
          if (r < 10) begin
            send_frame(0, 3 + $urandom_range(1, 0), 1'b1);
          end else if (r < 70) begin
            len = $urandom_range(6, 1);
            send_frame(len, 3 + len + ($urandom_range(3, 0) == 0), 1'b1);
          end else if (r < 80) begin
            len = $urandom_range(24, 10);
            send_frame(len, 3 + len, 1'b1);
          end else if (r < 90) begin
            // message cut short, the next frame_start abandons it
            len = $urandom_range(8, 1);
            send_frame(len, $urandom_range(2 + len, 1), 1'b1);
          end else if (r < 95) begin
            // any length up to all ones, only a few payload bytes
            send_frame($urandom_range(24'hFFFFFF, 0), $urandom_range(6, 3), 1'b1);
          end else begin
            repeat (10) send_noise($urandom_range(9, 0) == 0, 1'b1);
          end
        end
      end
      phase++;
    end

    wait_quiet();
    $display("covered %0d items, %0d of them encoded pairs in frames, over %0d threshold settings",
             items_sent, frame_pairs, settings_used);
    $display("checked %0d results, %0d of them closing a message", results_seen, messages_done);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### sim.f
design/spbe_pkg.sv
design/spbe_front.sv
design/spbe_cmd_queue.sv
design/spbe_back.sv
design/stego_pair_bit_extractor_unit.sv
tb/sv/stego_pair_bit_extractor_checker.sv
tb/sv/stego_pair_bit_extractor_unit_tb.sv
